[sv/tld_pkg.sv]
`default_nettype none

package tld_pkg;

  // field widths
  localparam int CNT_W  = 6;
  localparam int DATA_W = 8;
  localparam int KIND_W = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

  // telnet command bytes
  localparam logic [DATA_W-1:0] CH_IAC  = 8'd255;
  localparam logic [DATA_W-1:0] CH_WILL = 8'd251;
  localparam logic [DATA_W-1:0] CH_DONT = 8'd254;
  localparam logic [DATA_W-1:0] CH_SB   = 8'd250;
  localparam logic [DATA_W-1:0] CH_SE   = 8'd240;

  // line editing bytes
  localparam logic [DATA_W-1:0] CH_DEL = 8'd127;
  localparam logic [DATA_W-1:0] CH_BS  = 8'd8;
  localparam logic [DATA_W-1:0] CH_SP  = 8'd32;
  localparam logic [DATA_W-1:0] CH_CR  = 8'd13;
  localparam logic [DATA_W-1:0] CH_LF  = 8'd10;

  // editing operations handed from the parser to the line editor
  typedef enum logic [1:0] {
    OP_CHAR,
    OP_ERASE,
    OP_CR,
    OP_LF
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] ch;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  len;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

[sv/tld_front.sv]
`default_nettype none

module tld_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [tld_pkg::DATA_W-1:0] in_byte,
  output logic                     push,
  output tld_pkg::cmd_t            push_cmd,
  input  wire                      q_ready
);

  localparam logic [2:0] M_TEXT    = 3'd0;
  localparam logic [2:0] M_CMD     = 3'd1;
  localparam logic [2:0] M_OPT     = 3'd2;
  localparam logic [2:0] M_SUB     = 3'd3;
  localparam logic [2:0] M_SUB_IAC = 3'd4;

  logic [2:0] mode;
  logic [2:0] mode_next;
  logic       keep;
  logic       acc;

  // negotiation parser and byte classifier
  always_comb begin
    mode_next    = mode;
    keep         = 1'b0;
    push_cmd.op  = tld_pkg::OP_CHAR;
    push_cmd.ch  = in_byte;
    unique case (mode)
      M_CMD: begin
        if (in_byte >= tld_pkg::CH_WILL && in_byte <= tld_pkg::CH_DONT) begin
          mode_next = M_OPT;
        end else if (in_byte == tld_pkg::CH_SB) begin
          mode_next = M_SUB;
        end else begin
          mode_next = M_TEXT;
        end
      end
      M_OPT: begin
        mode_next = M_TEXT;
      end
      M_SUB: begin
        if (in_byte == tld_pkg::CH_IAC) begin
          mode_next = M_SUB_IAC;
        end
      end
      M_SUB_IAC: begin
        mode_next = (in_byte == tld_pkg::CH_SE) ? M_TEXT : M_SUB;
      end
      default: begin
        mode_next = M_TEXT;
        if (in_byte[7]) begin
          if (in_byte == tld_pkg::CH_IAC) begin
            mode_next = M_CMD;
          end
        end else begin
          keep = 1'b1;
          if (in_byte == tld_pkg::CH_CR) begin
            push_cmd.op = tld_pkg::OP_CR;
          end else if (in_byte == tld_pkg::CH_LF) begin
            push_cmd.op = tld_pkg::OP_LF;
          end else if (in_byte == tld_pkg::CH_BS || in_byte == tld_pkg::CH_DEL) begin
            push_cmd.op = tld_pkg::OP_ERASE;
          end
        end
      end
    endcase
  end

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;
  assign push     = acc && keep;

  // parser mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_TEXT;
    end else if (acc) begin
      mode <= mode_next;
    end
  end

endmodule

`default_nettype wire

[sv/tld_queue.sv]
`default_nettype none

module tld_queue (
  input  wire           clk,
  input  wire           rst,
  input  wire           wr_valid,
  output logic          wr_ready,
  input  tld_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  wire           rd_ready,
  output tld_pkg::cmd_t rd_cmd
);

  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = 1;
  localparam int FILL_W  = 2;

  tld_pkg::cmd_t        entries [Q_DEPTH];
  logic [PTR_W-1:0]     wptr;
  logic [PTR_W-1:0]     rptr;
  logic [FILL_W-1:0]    fill;
  logic                 do_wr;
  logic                 do_rd;

  assign wr_ready = (fill != FILL_W'(Q_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = entries[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tld_back.sv]
`default_nettype none

module tld_back #(
  parameter int LINE_MAX = 48
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           cmd_valid,
  output logic          cmd_ready,
  input  tld_pkg::cmd_t cmd,
  output logic          out_valid,
  input  wire           out_ready,
  output tld_pkg::res_t out_res
);

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [tld_pkg::CNT_W-1:0] LMAX = tld_pkg::CNT_W'(LINE_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LINE = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_CR   = 3'd3;
  localparam logic [2:0] S_LF   = 3'd4;
  localparam logic [2:0] S_SP   = 3'd5;
  localparam logic [2:0] S_BS2  = 3'd6;

  logic [tld_pkg::DATA_W-1:0] line_store [LINE_MAX];
  logic [tld_pkg::DATA_W-1:0] rd_data;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [tld_pkg::CNT_W-1:0]  count;
  logic [tld_pkg::CNT_W-1:0]  count_next;
  logic [tld_pkg::CNT_W-1:0]  idx;
  logic [tld_pkg::CNT_W-1:0]  idx_next;
  logic                       out_free;
  logic                       load;
  tld_pkg::res_t              res_next;

  assign out_free = !out_valid || out_ready;

  // line editor sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    load       = 1'b0;
    res_next   = '0;
    cmd_ready  = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            tld_pkg::OP_CHAR: begin
              if (count < LMAX) begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
                if (cmd.ch >= tld_pkg::CH_SP) begin
                  load          = 1'b1;
                  res_next.kind = tld_pkg::KIND_ECHO;
                  res_next.data = cmd.ch;
                  res_next.last = 1'b1;
                end
              end
            end
            tld_pkg::OP_ERASE: begin
              if (count != '0) begin
                count_next    = count - 1'b1;
                load          = 1'b1;
                res_next.kind = tld_pkg::KIND_ECHO;
                res_next.data = tld_pkg::CH_BS;
                state_next    = S_SP;
              end
            end
            default: begin
              // carriage return always ends the line, line feed only a non-empty one
              if (cmd.op == tld_pkg::OP_CR || count != '0) begin
                idx_next   = '0;
                state_next = (count == '0) ? S_MARK : S_LINE;
              end
            end
          endcase
        end
      end
      S_LINE: begin
        rd_addr = idx[AW-1:0];
        if (out_free) begin
          load          = 1'b1;
          res_next.kind = tld_pkg::KIND_LINE;
          res_next.data = rd_data;
          idx_next      = idx + 1'b1;
          if (idx_next == count) begin
            state_next = S_MARK;
          end else begin
            rd_addr = idx_next[AW-1:0];
          end
        end
      end
      S_MARK: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.kind = tld_pkg::KIND_MARK;
          res_next.len  = count;
          count_next    = '0;
          state_next    = S_CR;
        end
      end
      S_CR: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.kind = tld_pkg::KIND_ECHO;
          res_next.data = tld_pkg::CH_CR;
          state_next    = S_LF;
        end
      end
      S_LF: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.kind = tld_pkg::KIND_ECHO;
          res_next.data = tld_pkg::CH_LF;
          res_next.last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SP: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.kind = tld_pkg::KIND_ECHO;
          res_next.data = tld_pkg::CH_SP;
          state_next    = S_BS2;
        end
      end
      S_BS2: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.kind = tld_pkg::KIND_ECHO;
          res_next.data = tld_pkg::CH_BS;
          res_next.last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // line memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[count[AW-1:0]] <= cmd.ch;
    end
    rd_data <= line_store[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res_next;
    end
  end

endmodule

`default_nettype wire

[sv/telnet_line_discipline_core.sv]
`default_nettype none

// Telnet line discipline. Each received byte enters on the s_ side; Telnet
// negotiation (IAC commands, option bytes, subnegotiation up to IAC SE) and
// other bytes above 127 are consumed by the parser and give no result. Kept
// bytes pass through a two-entry queue to the line editor, which owns the
// line memory and the output register. A stored character echoes itself
// when printable, an erase echoes BS, space, BS, and a line end starts the
// memory read as the command is taken, then sends one item per stored
// character, then the marker, CR and LF. The line memory is read one entry
// per cycle while the output is not stalled. Each result carries tlast on
// the final item caused by its input byte; output backpressure stalls the
// editor, and the queue lets the parser keep taking bytes meanwhile until
// it is full.
module telnet_line_discipline_core #(
  parameter int LINE_MAX = 48
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // rx_byte [7:0]
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // data [7:0], line_length [13:8], zero [15:14]
  output logic [1:0] m_tuser,   // kind [1:0]
  output logic       m_tlast
);

  logic          push;
  tld_pkg::cmd_t push_cmd;
  logic          q_ready;
  logic          q_valid;
  logic          q_pop;
  tld_pkg::cmd_t q_cmd;
  tld_pkg::res_t res;

  // negotiation parser
  tld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  // queue between parser and editor
  tld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (q_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_pop),
    .rd_cmd   (q_cmd)
  );

  // line editor
  tld_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_pop),
    .cmd       (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result packing
  assign m_tdata = {2'b00, res.len, res.data};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

`ifndef ASSERT_OFF
  // a marker is zero-data, within line bounds and never the final item
  a_mark_shape : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tld_pkg::KIND_MARK) |->
      (m_tdata[7:0] == 8'd0 && m_tdata[13:8] <= 6'(LINE_MAX) && !m_tlast))
    else $error("malformed line complete marker");

  // line characters are always followed by the marker
  a_line_not_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tld_pkg::KIND_LINE) |-> !m_tlast)
    else $error("line character flagged as final item");

  // the CR echo follows a taken marker in the next cycle
  a_mark_then_cr : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser == tld_pkg::KIND_MARK) |=>
      (m_tvalid && m_tuser == tld_pkg::KIND_ECHO && m_tdata[7:0] == tld_pkg::CH_CR))
    else $error("marker not followed by CR echo");
`endif

endmodule

`default_nettype wire

[bench/telnet_line_checker.sv]
`timescale 1ns / 100ps

module telnet_line_checker #(
  parameter int LINE_MAX = 48
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire  [7:0] s_tdata,   // rx_byte [7:0]
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [15:0] m_tdata,   // data [7:0], line_length [13:8], zero [15:14]
  input  wire  [1:0] m_tuser,   // kind [1:0]
  input  wire        m_tlast,
  output int         fail_count,
  output int         outstanding
);

  typedef enum logic [2:0] {
    PM_TEXT,
    PM_CMD,
    PM_OPT,
    PM_SUB,
    PM_SUB_IAC
  } parse_mode_t;

  // shadow of the parser and line editor
  parse_mode_t mode;
  logic [7:0]  line_mem [0:LINE_MAX-1];
  int          line_cnt;

  // results of one byte, staged before tlast is known
  tld_pkg::res_t burst [0:LINE_MAX+3];
  int            nburst;

  // echoes, line items and markers still owed by the block
  tld_pkg::res_t echo_q [$];
  int            errs;

  initial fail_count = 0;
  initial outstanding = 0;

  task automatic stage(input logic [tld_pkg::KIND_W-1:0] kind, input logic [7:0] data,
                       input logic [tld_pkg::CNT_W-1:0] len);
    burst[nburst].kind = kind;
    burst[nburst].data = data;
    burst[nburst].len  = len;
    burst[nburst].last = 1'b0;
    nburst++;
  endtask

  // work out what one received byte makes the block send
  task automatic edit_line(input logic [7:0] b);
    bit text;
    text = 1'b0;
    nburst = 0;
    case (mode)
      PM_CMD: begin
        if (b >= tld_pkg::CH_WILL && b <= tld_pkg::CH_DONT) mode = PM_OPT;
        else if (b == tld_pkg::CH_SB) mode = PM_SUB;
        else mode = PM_TEXT;
      end
      PM_OPT: mode = PM_TEXT;
      PM_SUB: begin
        if (b == tld_pkg::CH_IAC) mode = PM_SUB_IAC;
      end
      PM_SUB_IAC: mode = (b == tld_pkg::CH_SE) ? PM_TEXT : PM_SUB;
      default: text = 1'b1;
    endcase
    if (text) begin
      mode = PM_TEXT;
      if (b > tld_pkg::CH_DEL) begin
        if (b == tld_pkg::CH_IAC) mode = PM_CMD;
      end else if (b == tld_pkg::CH_CR || (b == tld_pkg::CH_LF && line_cnt != 0)) begin
        for (int i = 0; i < line_cnt; i++) stage(tld_pkg::KIND_LINE, line_mem[i], '0);
        stage(tld_pkg::KIND_MARK, 8'd0, line_cnt[tld_pkg::CNT_W-1:0]);
        stage(tld_pkg::KIND_ECHO, tld_pkg::CH_CR, '0);
        stage(tld_pkg::KIND_ECHO, tld_pkg::CH_LF, '0);
        line_cnt = 0;
      end else if (b == tld_pkg::CH_LF) begin
        // lf on an empty line does nothing
      end else if (b == tld_pkg::CH_BS || b == tld_pkg::CH_DEL) begin
        if (line_cnt != 0) begin
          line_cnt--;
          stage(tld_pkg::KIND_ECHO, tld_pkg::CH_BS, '0);
          stage(tld_pkg::KIND_ECHO, tld_pkg::CH_SP, '0);
          stage(tld_pkg::KIND_ECHO, tld_pkg::CH_BS, '0);
        end
      end else if (line_cnt < LINE_MAX) begin
        line_mem[line_cnt] = b;
        line_cnt++;
        if (b >= tld_pkg::CH_SP) stage(tld_pkg::KIND_ECHO, b, '0);
      end
    end
    for (int i = 0; i < nburst; i++) begin
      if (i == nburst - 1) burst[i].last = 1'b1;
      echo_q.push_back(burst[i]);
    end
  endtask

  // watch both channels and compare each result with the oldest expectation
  always @(posedge clk) begin
    tld_pkg::res_t want;
    errs = 0;
    if (rst) begin
      mode = PM_TEXT;
      line_cnt = 0;
      echo_q.delete();
    end else begin
      if (s_tvalid && s_tready) edit_line(s_tdata);
      if (m_tvalid && m_tready) begin
        if (echo_q.size() == 0) begin
          $error("result item with nothing expected: tuser %0d tdata %h tlast %0d",
                 m_tuser, m_tdata, m_tlast);
          errs++;
        end else begin
          want = echo_q.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            errs++;
          end
          if (m_tdata[7:0] !== want.data) begin
            $error("data: expected %h, got %h", want.data, m_tdata[7:0]);
            errs++;
          end
          if (m_tdata[13:8] !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, m_tdata[13:8]);
            errs++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            errs++;
          end
          if (m_tdata[15:14] !== 2'b00) begin
            $error("tdata padding: expected 0, got %0d", m_tdata[15:14]);
            errs++;
          end
        end
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= echo_q.size();
  end

endmodule

[bench/tb_telnet_line_discipline_core.sv]
`timescale 1ns / 100ps

module tb_telnet_line_discipline_core;

  localparam int LINE_MAX  = 48;
  localparam int NUM_ITEMS = 370;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic  [7:0] s_tdata = 8'd0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire   [1:0] m_tuser;
  wire         m_tlast;

  int fail_count;
  int outstanding;
  int sent_items = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  telnet_line_discipline_core #(.LINE_MAX(LINE_MAX)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  telnet_line_checker #(.LINE_MAX(LINE_MAX)) line_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // run limit
  initial begin
    #6_000_000;
    $display("FAIL telnet_line_discipline_core");
    $finish;
  end

  // receiver: random stall before each result item
  initial begin : sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    sent_items++;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the sender until every expected result is out, then let it settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // short line with random edits, ended by cr or lf
  task automatic random_line(input int maxlen);
    int n;
    n = $urandom_range(0, maxlen);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: send_byte($urandom_range(0, 1) ? tld_pkg::CH_BS : tld_pkg::CH_DEL);
        1: send_byte(8'($urandom_range(0, 31)));
        default: send_byte(8'($urandom_range(32, 126)));
      endcase
    end
    send_byte($urandom_range(0, 1) ? tld_pkg::CH_CR : tld_pkg::CH_LF);
  endtask

  // line near or past the buffer size
  task automatic long_line();
    int n;
    n = $urandom_range(LINE_MAX - 2, LINE_MAX + 6);
    repeat (n) send_byte(8'($urandom_range(32, 126)));
    send_byte(tld_pkg::CH_CR);
  endtask

  // negotiation sequences and dropped high bytes
  task automatic random_telnet();
    int n;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        send_byte(tld_pkg::CH_IAC);
        send_byte(8'($urandom_range(tld_pkg::CH_WILL, tld_pkg::CH_DONT)));
        send_byte(8'($urandom));
      end
      1: begin
        send_byte(tld_pkg::CH_IAC);
        send_byte(tld_pkg::CH_SB);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            // iac inside subnegotiation followed by anything but se
            b = 8'($urandom_range(0, 254));
            if (b == tld_pkg::CH_SE) b = tld_pkg::CH_IAC;
            send_byte(tld_pkg::CH_IAC);
            send_byte(b);
          end else begin
            send_byte(8'($urandom));
          end
        end
        send_byte(tld_pkg::CH_IAC);
        send_byte(tld_pkg::CH_SE);
      end
      2: begin
        send_byte(tld_pkg::CH_IAC);
        send_byte(8'($urandom));
      end
      default: send_byte(8'($urandom_range(128, 254)));
    endcase
  endtask

  initial begin : stim
    bit paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // line editing corners
    send_byte(8'h00);          // control byte stored silently
    send_byte(tld_pkg::CH_SP);
    send_byte(8'h7E);
    send_byte(tld_pkg::CH_BS);
    send_byte(tld_pkg::CH_DEL);
    send_byte(tld_pkg::CH_CR);
    send_byte(tld_pkg::CH_CR); // empty line gives a zero-length marker
    send_byte(tld_pkg::CH_LF); // lf on empty line is ignored
    send_byte(tld_pkg::CH_BS); // erase on empty line is ignored
    send_byte(8'h78);
    send_byte(tld_pkg::CH_LF);
    // dropped bytes and negotiation
    send_byte(8'h80);
    send_byte(8'hFE);
    send_byte(tld_pkg::CH_IAC);
    send_byte(tld_pkg::CH_WILL);
    send_byte(8'hFF);
    send_byte(tld_pkg::CH_IAC);
    send_byte(tld_pkg::CH_SB);
    send_byte(8'h71);
    send_byte(tld_pkg::CH_IAC);
    send_byte(tld_pkg::CH_IAC); // back into subnegotiation
    send_byte(tld_pkg::CH_IAC);
    send_byte(tld_pkg::CH_SE);
    send_byte(tld_pkg::CH_IAC);
    send_byte(8'hF1);
    send_byte(tld_pkg::CH_IAC);
    send_byte(tld_pkg::CH_IAC);
    send_byte(8'h6B);
    send_byte(tld_pkg::CH_CR);
    drain();

    // random part, mostly well-formed lines
    long_line();
    while (sent_items < NUM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      if (!paused && sent_items > NUM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      case ($urandom_range(0, 19))
        0, 1, 2: random_telnet();
        3: send_byte(8'($urandom));
        4: long_line();
        default: random_line(8);
      endcase
    end
    drain();

    if (fail_count == 0) begin
      $display("PASS telnet_line_discipline_core");
    end else begin
      $display("FAIL telnet_line_discipline_core");
    end
    $finish;
  end

endmodule
